[sv/ahs_pkg.sv]
// shared types, constants and round function for the ascon hash sponge
package ahs_pkg;

    localparam int unsigned MaxRounds = 12;

    typedef logic [4:0][63:0] t_state;

    typedef struct packed {
        logic load;
        logic start;
    } t_perm_ctl;

    function automatic logic [63:0] rotr(input logic [63:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (64 - n));
    endfunction

    // one round: constant addition, s-box layer, linear layer
    function automatic t_state round_fn(input t_state s_in, input logic [3:0] rnd);
        t_state s;
        t_state t;
        s = s_in;
        s[2] = s[2] ^ {56'h0, 4'hf - rnd, rnd};
        s[0] = s[0] ^ s[4];
        s[4] = s[4] ^ s[3];
        s[2] = s[2] ^ s[1];
        t[0] = ~s[0] & s[1];
        t[1] = ~s[1] & s[2];
        t[2] = ~s[2] & s[3];
        t[3] = ~s[3] & s[4];
        t[4] = ~s[4] & s[0];
        s[0] = s[0] ^ t[1];
        s[1] = s[1] ^ t[2];
        s[2] = s[2] ^ t[3];
        s[3] = s[3] ^ t[4];
        s[4] = s[4] ^ t[0];
        s[1] = s[1] ^ s[0];
        s[0] = s[0] ^ s[4];
        s[3] = s[3] ^ s[2];
        s[2] = ~s[2];
        s[0] = s[0] ^ rotr(s[0], 19) ^ rotr(s[0], 28);
        s[1] = s[1] ^ rotr(s[1], 61) ^ rotr(s[1], 39);
        s[2] = s[2] ^ rotr(s[2], 1) ^ rotr(s[2], 6);
        s[3] = s[3] ^ rotr(s[3], 10) ^ rotr(s[3], 17);
        s[4] = s[4] ^ rotr(s[4], 7) ^ rotr(s[4], 41);
        round_fn = s;
    endfunction

endpackage

[sv/ahs_if.sv]
// handshake channels for message bytes and digest words
interface ahs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       last;
    modport source (output valid, msg_byte, byte_valid, last, input ready);
    modport sink (input valid, msg_byte, byte_valid, last, output ready);
endinterface

interface ahs_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

[sv/ahs_perm.sv]
// iterative permutation, one round per cycle, holds the sponge state
module ahs_perm #(
    parameter int unsigned ROUNDS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ahs_pkg::t_perm_ctl i_ctl,
    input  ahs_pkg::t_state   i_state,
    output ahs_pkg::t_state   o_state,
    output logic              o_busy
);
    localparam logic [3:0] RndFirst = 4'(ahs_pkg::MaxRounds - ROUNDS);
    localparam logic [3:0] RndLast  = 4'(ahs_pkg::MaxRounds - 1);

    ahs_pkg::t_state r_s;
    logic [3:0]      r_rnd;
    logic            r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rnd  <= RndFirst;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_rnd  <= RndFirst;
        end else if (r_busy) begin
            r_rnd <= r_rnd + 4'd1;
            if (r_rnd == RndLast) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_s <= i_state;
        end else if (r_busy) begin
            r_s <= ahs_pkg::round_fn(r_s, r_rnd);
        end
    end

    assign o_state = r_s;
    assign o_busy  = r_busy;
endmodule

[sv/ascon_hash_sponge.sv]
// top level: byte packing, padding, squeeze sequencing around the permutation
//
//  channel | dir | payload                                | accepted when
//  i_in    | in  | msg_byte[8], byte_valid, last          | valid & ready
//  o_out   | out | digest_word[64], word_index[2], last_w | valid & ready
//
// a byte word is taken and shifted into the 56-bit block register;
// the byte that completes a block starts the permutation
// a last word goes through the pad state, then a permutation per digest word
// plus the wait of that word in the output register, then a permutation
// to rebuild the initial state
// after reset the initial permutation runs, no input taken
// a stalled output holds its word and the block takes no input meanwhile
module ascon_hash_sponge #(
    parameter int unsigned ROUNDS       = 12,
    parameter int unsigned DIGEST_WORDS = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ahs_in_if.sink    i_in,
    ahs_out_if.source o_out
);
    localparam int unsigned KW = $clog2(DIGEST_WORDS + 1);
    localparam logic [KW-1:0] KLast = KW'(DIGEST_WORDS - 1);
    localparam logic [63:0] Iv0 = {8'h00, 8'd64, 8'(ROUNDS), 24'h0,
                                   16'(64 * DIGEST_WORDS)};

    // sequencer codes
    localparam logic [2:0] S_BOOT = 3'd0;  // load initial value
    localparam logic [2:0] S_IDLE = 3'd1;  // take bytes
    localparam logic [2:0] S_ABS  = 3'd2;  // full block permuting
    localparam logic [2:0] S_PAD  = 3'd3;  // absorb padded tail
    localparam logic [2:0] S_SQZ  = 3'd4;  // permute before a digest word
    localparam logic [2:0] S_OUT  = 3'd5;  // digest word waits
    localparam logic [2:0] S_INIT = 3'd6;  // rebuild initial state

    logic [2:0]    r_st, n_st;
    logic [55:0]   r_blk;
    logic [2:0]    r_cnt, n_cnt;
    logic          r_pend, n_pend;
    logic [KW-1:0] r_k, n_k;
    logic          r_ovalid, n_ovalid;
    logic [63:0]   r_oword;
    logic [1:0]    r_oidx;
    logic          r_olast;

    ahs_pkg::t_perm_ctl perm_ctl;
    ahs_pkg::t_state    perm_in, perm_st;
    logic               perm_busy;
    logic               in_take, out_take;
    logic [63:0]        pad_word;
    logic [63:0]        full_word;
    logic [KW+1:0]      k_ext;

    ahs_perm #(.ROUNDS(ROUNDS)) u_perm (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (perm_ctl),
        .i_state(perm_in),
        .o_state(perm_st),
        .o_busy (perm_busy)
    );

    assign i_in.ready = (r_st == S_IDLE);
    assign in_take    = i_in.valid && i_in.ready;
    assign out_take   = r_ovalid && o_out.ready;

    // buffered bytes then 0x80, moved up to the top of the word
    assign pad_word  = {r_blk, 8'h80} << {(3'd7 - r_cnt), 3'b000};
    assign full_word = {r_blk, i_in.msg_byte};
    assign k_ext     = {2'b00, r_k};

    always_comb begin
        n_st     = r_st;
        n_cnt    = r_cnt;
        n_pend   = r_pend;
        n_k      = r_k;
        n_ovalid = r_ovalid;
        perm_ctl = '0;
        perm_in  = perm_st;
        case (r_st)
            S_BOOT: begin
                perm_in  = {256'h0, Iv0};
                perm_ctl = '{load: 1'b1, start: 1'b1};
                n_st     = S_INIT;
            end
            S_IDLE: begin
                if (in_take) begin
                    if (i_in.byte_valid && r_cnt == 3'd7) begin
                        // completed block goes straight into word 0
                        perm_in[0] = perm_st[0] ^ full_word;
                        perm_ctl   = '{load: 1'b1, start: 1'b1};
                        n_cnt      = 3'd0;
                        n_pend     = i_in.last;
                        n_st       = S_ABS;
                    end else begin
                        if (i_in.byte_valid) begin
                            n_cnt = r_cnt + 3'd1;
                        end
                        if (i_in.last) begin
                            n_st = S_PAD;
                        end
                    end
                end
            end
            S_ABS: begin
                if (!perm_busy) begin
                    n_st   = r_pend ? S_PAD : S_IDLE;
                    n_pend = 1'b0;
                end
            end
            S_PAD: begin
                perm_in[0] = perm_st[0] ^ pad_word;
                perm_ctl   = '{load: 1'b1, start: 1'b1};
                n_cnt      = 3'd0;
                n_k        = '0;
                n_st       = S_SQZ;
            end
            S_SQZ: begin
                if (!perm_busy) begin
                    n_ovalid = 1'b1;
                    n_st     = S_OUT;
                end
            end
            S_OUT: begin
                if (out_take) begin
                    n_ovalid = 1'b0;
                    if (r_k == KLast) begin
                        perm_in  = {256'h0, Iv0};
                        perm_ctl = '{load: 1'b1, start: 1'b1};
                        n_k      = '0;
                        n_st     = S_INIT;
                    end else begin
                        perm_ctl = '{load: 1'b0, start: 1'b1};
                        n_k      = r_k + KW'(1);
                        n_st     = S_SQZ;
                    end
                end
            end
            S_INIT: begin
                if (!perm_busy) begin
                    n_st = S_IDLE;
                end
            end
            default: begin
                n_st = S_BOOT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_BOOT;
            r_cnt    <= 3'd0;
            r_pend   <= 1'b0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_cnt    <= n_cnt;
            r_pend   <= n_pend;
            r_k      <= n_k;
            r_ovalid <= n_ovalid;
        end
    end

    // byte shift line, newest byte at the bottom
    always_ff @(posedge i_clk) begin
        if (in_take && i_in.byte_valid) begin
            r_blk <= {r_blk[47:0], i_in.msg_byte};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_st == S_SQZ && !perm_busy) begin
            r_oword <= perm_st[0];
            r_oidx  <= k_ext[1:0];
            r_olast <= (r_k == KLast);
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.digest_word = r_oword;
    assign o_out.word_index  = r_oidx;
    assign o_out.last_word   = r_olast;

    // input is only taken while the round unit is quiet
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !perm_busy)
        else $error("input ready while permuting");

    // a word is shown only while the sequencer waits on it
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_st == S_OUT))
        else $error("output valid outside output state");

    // final word taken leads to rebuilding the initial state
    a_final_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && o_out.last_word) |=> (r_st == S_INIT && perm_busy))
        else $error("no reinit after final digest word");
endmodule
